// ===== rtl/core/hash_ring_partition_lookup_core_assert.svh =====
// Assertion macros for the hash ring partition lookup core.
// Used only by hash_ring_partition_lookup_core; empty when SYNTH is defined.
`ifndef HASH_RING_PARTITION_LOOKUP_CORE_ASSERT_SVH
`define HASH_RING_PARTITION_LOOKUP_CORE_ASSERT_SVH
`ifndef SYNTH
`define HRPL_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("hrpl assertion failed");
`define HRPL_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrpl assertion failed");
`else
`define HRPL_NEVER(label, cond)
`define HRPL_IMPLY(label, ante, cons)
`endif
`endif

// ===== rtl/core/hrpl_pkg.sv =====
// Shared constants for the hash ring partition lookup core.
// No dependencies.
package hrpl_pkg;
	localparam int MAX_PARTITIONS = 64;
	localparam int ADDR_W = $clog2(MAX_PARTITIONS);
	localparam int CNT_W = 7;
	localparam int VAL_W = 64;

	localparam logic [1:0] FN_LOOKUP = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;
	localparam logic [1:0] FN_FILL = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_BADCOUNT = 2'd3;
endpackage

// ===== rtl/core/hash_ring_partition_lookup_core.sv =====
// Hash ring partition lookup: sorted boundary table in one synchronous RAM.
// Depends on hrpl_pkg and hash_ring_partition_lookup_core_assert.svh.
// Clear, empty lookup and bad fill finish straight from idle. Lookup/insert: binary search
// of up to 7 probes, then a read at the found position; insert shifts larger entries up
// one at a time. Fill: bit-serial divide, then one write per boundary. Results never stall.
// One item at a time (busy); next transfer at the done cycle. Reset clears FSM and count.
`include "hash_ring_partition_lookup_core_assert.svh"
module hash_ring_partition_lookup_core
	import hrpl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       func,
	input  logic [VAL_W-1:0] value,
	input  logic [CNT_W-1:0] count,
	output logic             done,
	output logic [VAL_W-1:0] partition,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] entries
);
	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SCMP, S_RDPOS, S_RES, S_SHR, S_SHW, S_DIV, S_FILL
	} state_t;

	state_t state_q;

	// latched command
	logic [1:0]       func_q;
	logic [VAL_W-1:0] value_q;
	logic [CNT_W-1:0] fcount_q;

	logic [CNT_W-1:0] cnt_q;   // entries held
	logic [CNT_W-1:0] lo_q, hi_q, mid_q, k_q;
	logic [VAL_W-1:0] acc_q;   // divider quotient, then running boundary
	logic [CNT_W-1:0] rem_q;
	logic [$clog2(VAL_W)-1:0] dcnt_q;
	// step held apart from the running boundary
	logic [VAL_W-1:0] step_q;

	// boundary RAM, one write and one read port, registered read
	logic [VAL_W-1:0] mem [MAX_PARTITIONS];
	logic [VAL_W-1:0] rdata;
	logic             we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [VAL_W-1:0] wdata;

	logic [CNT_W-1:0] mid;
	logic [CNT_W:0]   rem2, dsub;
	logic             qbit;
	logic             present;

	assign busy = (state_q != S_IDLE);
	assign mid = CNT_W'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));

	// restoring divide step: all-ones dividend feeds a 1 each cycle
	assign rem2 = {rem_q, 1'b1};
	assign dsub = rem2 - {1'b0, fcount_q};
	assign qbit = (rem2 >= {1'b0, fcount_q});

	assign present = (lo_q < cnt_q) && (rdata == value_q);

	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = value_q;
		case (state_q)
			S_SRCH: raddr = mid[ADDR_W-1:0];
			S_RDPOS: raddr = (lo_q < cnt_q) ? lo_q[ADDR_W-1:0] : '0;
			S_SHR: raddr = ADDR_W'(k_q - 1'b1);
			S_SHW: begin
				we = 1'b1;
				waddr = k_q[ADDR_W-1:0];
				wdata = rdata;
			end
			S_RES: begin
				// insert of a new value once the shift is done (or nothing to shift)
				if (func_q == FN_INSERT && !present && cnt_q < CNT_W'(MAX_PARTITIONS)
						&& k_q <= lo_q) begin
					we = 1'b1;
					waddr = lo_q[ADDR_W-1:0];
				end
			end
			S_FILL: begin
				we = 1'b1;
				waddr = ADDR_W'(k_q - 1'b1);
				wdata = (k_q == fcount_q) ? {VAL_W{1'b1}} : acc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
			partition <= '0;
			status <= ST_OK;
			entries <= '0;
			func_q <= FN_LOOKUP;
			value_q <= '0;
			fcount_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			k_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			dcnt_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q <= func;
						value_q <= value;
						fcount_q <= count;
						lo_q <= '0;
						hi_q <= cnt_q;
						rem_q <= '0;
						dcnt_q <= '0;
						partition <= '0;
						status <= ST_OK;
						entries <= cnt_q;
						case (func)
							FN_LOOKUP: begin
								if (cnt_q == '0) begin
									status <= ST_EMPTY;
									done <= 1'b1;
								end else begin
									state_q <= S_SRCH;
								end
							end
							FN_INSERT: state_q <= S_SRCH;
							FN_CLEAR: begin
								cnt_q <= '0;
								entries <= '0;
								done <= 1'b1;
							end
							default: begin
								if (count == '0 || count > CNT_W'(MAX_PARTITIONS)) begin
									status <= ST_BADCOUNT;
									done <= 1'b1;
								end else begin
									state_q <= S_DIV;
								end
							end
						endcase
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q <= mid;
						state_q <= S_SCMP;
					end else begin
						state_q <= S_RDPOS;
					end
				end
				S_SCMP: begin
					if (rdata < value_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH;
				end
				S_RDPOS: begin
					k_q <= cnt_q;
					state_q <= S_RES;
				end
				S_RES: begin
					if (func_q == FN_LOOKUP) begin
						partition <= rdata;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (present) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (cnt_q >= CNT_W'(MAX_PARTITIONS)) begin
						status <= ST_FULL;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (k_q > lo_q) begin
						state_q <= S_SHR;
					end else begin
						// new value written at lo this cycle
						cnt_q <= cnt_q + 1'b1;
						entries <= cnt_q + 1'b1;
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					k_q <= k_q - 1'b1;
					state_q <= S_RES;
				end
				S_DIV: begin
					rem_q <= qbit ? dsub[CNT_W-1:0] : rem2[CNT_W-1:0];
					acc_q <= {acc_q[VAL_W-2:0], qbit};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == '1) begin
						k_q <= CNT_W'(1);
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					// acc holds step * k; the divider result is kept in step_q
					acc_q <= acc_q + step_q;
					k_q <= k_q + 1'b1;
					if (k_q == fcount_q) begin
						cnt_q <= fcount_q;
						entries <= fcount_q;
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV && dcnt_q == '1) begin
			step_q <= {acc_q[VAL_W-2:0], qbit};
		end
	end

	`HRPL_NEVER(a_done_while_busy, done && busy)
	`HRPL_NEVER(a_count_bound, cnt_q > CNT_W'(MAX_PARTITIONS))
	`HRPL_IMPLY(a_empty_zero, done && status == ST_EMPTY, partition == '0 && entries == '0)
endmodule

// ===== tb/sv/tb_hash_ring_partition_lookup_core.sv =====
// Testbench for hash_ring_partition_lookup_core: directed and random transfers
// checked against a behavioral sorted-table model. Depends on hrpl_pkg and the core.
`timescale 1ns / 1ps
module tb_hash_ring_partition_lookup_core;
	import hrpl_pkg::*;

	localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [VAL_W-1:0] partition;
		logic [1:0]       status;
		logic [CNT_W-1:0] entries;
	} lookup_result_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       func;
	logic [VAL_W-1:0] value;
	logic [CNT_W-1:0] count;
	logic             done;
	logic [VAL_W-1:0] partition;
	logic [1:0]       status;
	logic [CNT_W-1:0] entries;

	// model state: sorted boundaries and how many are valid
	logic [VAL_W-1:0] ring [MAX_PARTITIONS];
	int               ring_len;
	lookup_result_t   pending_results [$];
	int               errors = 0;
	int               idle_cycles = 0;

	hash_ring_partition_lookup_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .value(value), .count(count), .done(done),
		.partition(partition), .status(status), .entries(entries)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// index of first boundary not below key, ring_len if none
	function automatic int ring_lower_bound(logic [VAL_W-1:0] key);
		int i;
		for (i = 0; i < ring_len; i++)
			if (ring[i] >= key) return i;
		return ring_len;
	endfunction

	function automatic lookup_result_t ring_apply(logic [1:0] f, logic [VAL_W-1:0] v,
			logic [CNT_W-1:0] c);
		lookup_result_t r;
		int pos;
		logic [VAL_W-1:0] step;
		r = '0;
		r.status = ST_OK;
		case (f)
			FN_LOOKUP: begin
				if (ring_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pos = ring_lower_bound(v);
					r.partition = (pos < ring_len) ? ring[pos] : ring[0];
				end
			end
			FN_INSERT: begin
				pos = ring_lower_bound(v);
				if (!(pos < ring_len && ring[pos] == v)) begin
					if (ring_len >= MAX_PARTITIONS) begin
						r.status = ST_FULL;
					end else begin
						for (int k = ring_len; k > pos; k--) ring[k] = ring[k-1];
						ring[pos] = v;
						ring_len++;
					end
				end
			end
			FN_CLEAR: begin
				ring_len = 0;
			end
			default: begin
				if (c == 0 || c > MAX_PARTITIONS) begin
					r.status = ST_BADCOUNT;
				end else begin
					step = ALL_ONES / VAL_W'(c);
					for (int i = 1; i <= c; i++)
						ring[i-1] = (i == c) ? ALL_ONES : step * VAL_W'(i);
					ring_len = c;
				end
			end
		endcase
		r.entries = CNT_W'(ring_len);
		return r;
	endfunction

	// mostly short gaps, now and then a long one; start stays high across a zero gap
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one transfer: hold start until busy drops, then push the prediction
	task automatic send_item(logic [1:0] f, logic [VAL_W-1:0] v, logic [CNT_W-1:0] c);
		start <= 1'b1;
		func  <= f;
		value <= v;
		count <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(ring_apply(f, v, c));
		idle_gap();
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		return {$urandom(), $urandom()};
	endfunction

	// value near or on an existing boundary, to exercise hits and neighbors
	function automatic logic [VAL_W-1:0] near_boundary();
		logic [VAL_W-1:0] b;
		if (ring_len == 0) return rand_value();
		b = ring[$urandom_range(0, ring_len - 1)];
		case ($urandom_range(0, 2))
			0: return b;
			1: return b + 1;
			default: return b - 1;
		endcase
	endfunction

	// checker: every strobe is compared to the oldest prediction
	always @(posedge clk) begin
		lookup_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result partition=%h status=%0d", partition, status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (partition !== e.partition) begin
					$error("partition exp %h got %h", e.partition, partition);
					errors++;
				end
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status);
					errors++;
				end
				if (entries !== e.entries) begin
					$error("entries exp %0d got %0d", e.entries, entries);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_hash_ring_partition_lookup_core NOT OK");
			$finish;
		end
	end

	task automatic test_empty_and_bad();
		send_item(FN_LOOKUP, '0, '0);
		send_item(FN_LOOKUP, ALL_ONES, '0);
		send_item(FN_FILL, '0, 7'd0);
		send_item(FN_FILL, '0, 7'd65);
		send_item(FN_FILL, '0, 7'd127);
		send_item(FN_CLEAR, ALL_ONES, 7'd127);
	endtask

	task automatic test_insert_lookup();
		send_item(FN_INSERT, 64'h8000_0000_0000_0000, '0);
		send_item(FN_INSERT, 64'h8000_0000_0000_0000, '0);   // duplicate
		send_item(FN_INSERT, '0, '0);
		send_item(FN_INSERT, ALL_ONES, '0);
		send_item(FN_LOOKUP, 64'h8000_0000_0000_0000, '0);   // exact hit
		send_item(FN_LOOKUP, 64'h8000_0000_0000_0001, '0);
		send_item(FN_LOOKUP, 64'd1, '0);
		send_item(FN_CLEAR, '0, '0);
		send_item(FN_INSERT, 64'd100, '0);
		send_item(FN_LOOKUP, 64'd101, '0);                   // wraps to smallest
	endtask

	task automatic test_fill_and_full();
		send_item(FN_FILL, rand_value(), 7'd1);
		send_item(FN_LOOKUP, '0, '0);
		send_item(FN_FILL, '0, 7'd3);
		send_item(FN_LOOKUP, ALL_ONES / 3 + 1, '0);
		send_item(FN_FILL, '0, 7'd64);
		send_item(FN_INSERT, 64'd5, '0);                     // full, new value
		send_item(FN_INSERT, ALL_ONES, '0);                  // full, present
		send_item(FN_LOOKUP, 64'd1, '0);
	endtask

	task automatic test_random();
		int sel;
		for (int n = 0; n < 1000; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				send_item(FN_LOOKUP, ($urandom_range(0, 1) != 0) ? near_boundary() : rand_value(),
					7'($urandom()));
			else if (sel < 80)
				send_item(FN_INSERT, ($urandom_range(0, 3) == 0) ? near_boundary() : rand_value(),
					7'($urandom()));
			else if (sel < 85)
				send_item(FN_CLEAR, rand_value(), 7'($urandom()));
			else if (sel < 95)
				// mostly small fills so inserts still have room afterward
				send_item(FN_FILL, rand_value(),
					($urandom_range(0, 4) == 0) ? 7'($urandom()) : 7'($urandom_range(1, 12)));
			else
				send_item(FN_FILL, rand_value(), 7'($urandom_range(60, 64)));
		end
	endtask

	initial begin
		ring_len = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_LOOKUP;
		value = '0;
		count = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_bad();
		test_insert_lookup();
		test_fill_and_full();
		test_random();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb_hash_ring_partition_lookup_core OK");
		else
			$display("tb_hash_ring_partition_lookup_core NOT OK");
		$finish;
	end
endmodule

// ===== hash_ring_partition_lookup_core.f =====
+incdir+rtl/core
rtl/core/hrpl_pkg.sv
rtl/core/hash_ring_partition_lookup_core.sv
tb/sv/tb_hash_ring_partition_lookup_core.sv
